### design/jac_pkg.sv
// Shared types and constants of the joystick auto-centering conditioner.
package jac_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_HALF_SPAN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECENTER_BAND  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECENTER_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_KICK      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_STREAK    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIENT_MODE    = 3'd6;

   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_FAIL   = 2'd1;
   localparam logic [1:0] FUNC_BIND   = 2'd2;
   localparam logic [1:0] FUNC_DETACH = 2'd3;

   localparam int ONE_Q14   = 16384;
   localparam int FAIL_MAX  = 15;
   localparam int ORIENT_SWAP  = 0;
   localparam int ORIENT_INV_X = 1;
   localparam int ORIENT_INV_Y = 2;

   typedef struct packed {
      logic [15:0] inv_half_span;
      logic [14:0] recenter_band;
      logic [15:0] recenter_gain;
      logic [11:0] move_threshold;
      logic [14:0] hold_kick;
      logic [3:0]  lost_streak;
      logic [2:0]  orient_mode;
   } cfg_type;

endpackage

### design/jac_ifs.sv
// Request, response and register write channel interfaces.
interface jac_req_if #(parameter int ADC_BITS = 12);
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [ADC_BITS-1:0] sample_x;
   logic [ADC_BITS-1:0] sample_y;
   modport source (output valid, output func, output sample_x, output sample_y, input ready);
   modport sink   (input valid, input func, input sample_x, input sample_y, output ready);
endinterface

interface jac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic               moved;
   logic               bound;
   logic               lost;
   modport source (output valid, output norm_x, output norm_y, output moved, output bound,
                   output lost, input ready);
   modport sink   (input valid, input norm_x, input norm_y, input moved, input bound,
                   input lost, output ready);
endinterface

interface jac_csr_if;
   import jac_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/jac_csr.sv
// Configuration register file of the conditioner.
module jac_csr (
   input  logic             clock,
   input  logic             reset,
   jac_csr_if.sink          csr_ch,
   output jac_pkg::cfg_type cfg
);
   import jac_pkg::*;

   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_half_span  <= 16'd32768;
         cfg_ff.recenter_band  <= 15'd1638;
         cfg_ff.recenter_gain  <= 16'd655;
         cfg_ff.move_threshold <= 12'd40;
         cfg_ff.hold_kick      <= 15'd4915;
         cfg_ff.lost_streak    <= 4'd5;
         cfg_ff.orient_mode    <= 3'd0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_INV_HALF_SPAN:  cfg_ff.inv_half_span  <= csr_ch.data;
            CSR_RECENTER_BAND:  cfg_ff.recenter_band  <= csr_ch.data[14:0];
            CSR_RECENTER_GAIN:  cfg_ff.recenter_gain  <= csr_ch.data;
            CSR_MOVE_THRESHOLD: cfg_ff.move_threshold <= csr_ch.data[11:0];
            CSR_HOLD_KICK:      cfg_ff.hold_kick      <= csr_ch.data[14:0];
            CSR_LOST_STREAK:    cfg_ff.lost_streak    <= csr_ch.data[3:0];
            CSR_ORIENT_MODE:    cfg_ff.orient_mode    <= csr_ch.data[2:0];
            default: ;
         endcase
      end
   end

endmodule

### design/jac_axis.sv
// Per-axis normalization against the fractional center and center adaptation.
module jac_axis #(
   parameter int ADC_BITS = 12
) (
   input  logic [ADC_BITS-1:0]  sample,
   input  logic [ADC_BITS+15:0] center,
   input  logic [15:0]          inv_half_span,
   input  logic [15:0]          recenter_gain,
   input  logic [14:0]          recenter_band,
   output logic signed [ADC_BITS+5:0] norm,
   output logic [ADC_BITS+15:0] center_next
);
   logic signed [ADC_BITS+16:0] offset;
   logic signed [ADC_BITS+33:0] prod_norm;
   logic signed [ADC_BITS+33:0] prod_gain;
   logic signed [ADC_BITS+17:0] update;
   logic        [ADC_BITS+5:0]  norm_mag;
   logic                        adapt;

   always_comb begin
      offset    = $signed({1'b0, sample, 16'd0}) - $signed({1'b0, center});
      prod_norm = offset * $signed({1'b0, inv_half_span});
      prod_gain = offset * $signed({1'b0, recenter_gain});
      norm      = prod_norm[ADC_BITS+33:28];
      update    = prod_gain[ADC_BITS+33:16];
      norm_mag  = norm[ADC_BITS+5] ? (ADC_BITS+6)'(0) - norm : norm;
      adapt     = 32'(norm_mag) < 32'(recenter_band);
      center_next = adapt ? center + update[ADC_BITS+15:0] : center;
   end

endmodule

### design/joystick_autocenter_conditioner_core.sv
// Top level of the joystick auto-centering conditioner.
//
// Requests arrive on req_ch: a func code with two samples (a sample, a read
// failure, a bind that carries the center, or a detach). Every request gives
// exactly one response on rsp_ch with the clamped Q2.14 deflections, the
// moved flag, the bound state after the request and the lost flag.
// Registers are written on csr_ch, which is always ready; the user must write
// them only while no request is in flight, which the block does not enforce.
// A request is held in an input register, then the axis arithmetic, the
// center update and the state update run combinationally into the response
// register. One request is taken every cycle while the receiver takes
// responses. The center adaptation loop is a subtract, one multiply and an
// add feeding the center register.
// When the receiver stalls, the response register holds and the input
// register fills; req_ch.ready then drops until the response is taken.
// Reset restores the register defaults, recenters both axes at midscale and
// leaves the stick unbound with no history.
module joystick_autocenter_conditioner_core #(
   parameter int ADC_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   jac_req_if.sink   req_ch,
   jac_rsp_if.source rsp_ch,
   jac_csr_if.sink   csr_ch
);
   import jac_pkg::*;

   localparam int CW = ADC_BITS + 16;
   localparam int NW = ADC_BITS + 7;
   localparam logic [CW-1:0] CENTER_RESET = CW'(1) << (CW - 1);

   cfg_type cfg;

   logic                in_valid_ff;
   logic [1:0]          func_ff;
   logic [ADC_BITS-1:0] sx_ff;
   logic [ADC_BITS-1:0] sy_ff;

   logic [CW-1:0]       center_x_ff, center_x_in;
   logic [CW-1:0]       center_y_ff, center_y_in;
   logic [ADC_BITS-1:0] prev_x_ff, prev_x_in;
   logic [ADC_BITS-1:0] prev_y_ff, prev_y_in;
   logic                have_prev_ff, have_prev_in;
   logic [3:0]          fail_count_ff, fail_count_in;
   logic                attached_ff, attached_in;

   logic               rsp_valid_ff;
   logic signed [15:0] norm_x_ff, norm_x_in;
   logic signed [15:0] norm_y_ff, norm_y_in;
   logic               moved_ff, moved_in;
   logic               lost_ff, lost_in;

   logic signed [ADC_BITS+5:0] raw_x, raw_y;
   logic [CW-1:0]              adapt_x, adapt_y;
   logic signed [NW-1:0]       rx, ry;
   logic [15:0]                mag_x, mag_y;
   logic [ADC_BITS-1:0]        dx, dy;
   logic [3:0]                 fail_inc;
   logic                       advance;
   logic                       fire;

   jac_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   jac_axis #(.ADC_BITS(ADC_BITS)) u_axis_x (
      .sample        (sx_ff),
      .center        (center_x_ff),
      .inv_half_span (cfg.inv_half_span),
      .recenter_gain (cfg.recenter_gain),
      .recenter_band (cfg.recenter_band),
      .norm          (raw_x),
      .center_next   (adapt_x)
   );

   jac_axis #(.ADC_BITS(ADC_BITS)) u_axis_y (
      .sample        (sy_ff),
      .center        (center_y_ff),
      .inv_half_span (cfg.inv_half_span),
      .recenter_gain (cfg.recenter_gain),
      .recenter_band (cfg.recenter_band),
      .norm          (raw_y),
      .center_next   (adapt_y)
   );

   function automatic logic signed [15:0] clamp_q14(input logic signed [NW-1:0] v);
      logic signed [15:0] r;
      if (int'(v) > ONE_Q14) begin
         r = 16'(ONE_Q14);
      end else if (int'(v) < -ONE_Q14) begin
         r = 16'(-ONE_Q14);
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.norm_x = norm_x_ff;
   assign rsp_ch.norm_y = norm_y_ff;
   assign rsp_ch.moved  = moved_ff;
   assign rsp_ch.bound  = attached_ff;
   assign rsp_ch.lost   = lost_ff;

   always_comb begin
      rx = cfg.orient_mode[ORIENT_SWAP] ? NW'(raw_y) : NW'(raw_x);
      ry = cfg.orient_mode[ORIENT_SWAP] ? NW'(raw_x) : NW'(raw_y);
      if (cfg.orient_mode[ORIENT_INV_X]) begin
         rx = -rx;
      end
      if (cfg.orient_mode[ORIENT_INV_Y]) begin
         ry = -ry;
      end
      dx = (sx_ff > prev_x_ff) ? sx_ff - prev_x_ff : prev_x_ff - sx_ff;
      dy = (sy_ff > prev_y_ff) ? sy_ff - prev_y_ff : prev_y_ff - sy_ff;
      if (!have_prev_ff) begin
         dx = '0;
         dy = '0;
      end
      fail_inc = (32'(fail_count_ff) < FAIL_MAX) ? fail_count_ff + 4'd1 : fail_count_ff;

      center_x_in   = center_x_ff;
      center_y_in   = center_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      have_prev_in  = have_prev_ff;
      fail_count_in = fail_count_ff;
      attached_in   = attached_ff;
      norm_x_in     = '0;
      norm_y_in     = '0;
      moved_in      = 1'b0;
      lost_in       = 1'b0;
      mag_x         = '0;
      mag_y         = '0;

      unique case (func_ff)
         FUNC_SAMPLE: begin
            if (attached_ff) begin
               fail_count_in = '0;
               prev_x_in     = sx_ff;
               prev_y_in     = sy_ff;
               have_prev_in  = 1'b1;
               center_x_in   = adapt_x;
               center_y_in   = adapt_y;
               norm_x_in     = clamp_q14(rx);
               norm_y_in     = clamp_q14(ry);
               mag_x         = norm_x_in[15] ? 16'd0 - norm_x_in : norm_x_in;
               mag_y         = norm_y_in[15] ? 16'd0 - norm_y_in : norm_y_in;
               moved_in      = (32'(dx) > 32'(cfg.move_threshold))
                            || (32'(dy) > 32'(cfg.move_threshold))
                            || (mag_x > {1'b0, cfg.hold_kick})
                            || (mag_y > {1'b0, cfg.hold_kick});
            end
         end
         FUNC_FAIL: begin
            if (attached_ff) begin
               fail_count_in = fail_inc;
               if (fail_inc >= cfg.lost_streak) begin
                  attached_in = 1'b0;
                  lost_in     = 1'b1;
               end
            end
         end
         FUNC_BIND: begin
            if (!attached_ff) begin
               attached_in   = 1'b1;
               fail_count_in = '0;
               have_prev_in  = 1'b0;
               center_x_in   = {sx_ff, 16'd0};
               center_y_in   = {sy_ff, 16'd0};
            end
         end
         FUNC_DETACH: begin
            attached_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         center_x_ff   <= CENTER_RESET;
         center_y_ff   <= CENTER_RESET;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_prev_ff  <= 1'b0;
         fail_count_ff <= '0;
         attached_ff   <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff  <= 1'b1;
            center_x_ff   <= center_x_in;
            center_y_ff   <= center_y_in;
            prev_x_ff     <= prev_x_in;
            prev_y_ff     <= prev_y_in;
            have_prev_ff  <= have_prev_in;
            fail_count_ff <= fail_count_in;
            attached_ff   <= attached_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         func_ff <= req_ch.func;
         sx_ff   <= req_ch.sample_x;
         sy_ff   <= req_ch.sample_y;
      end
      if (fire) begin
         norm_x_ff <= norm_x_in;
         norm_y_ff <= norm_y_in;
         moved_ff  <= moved_in;
         lost_ff   <= lost_in;
      end
   end

endmodule
